[sv/uer_pkg.sv]
// Shared constants for the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

  // Sensor count and field widths
  localparam int NUM_SENSORS = 8;
  localparam int CHAN_W      = 3;
  localparam int ECHO_W      = 8;
  localparam int COUNT_W     = 12;
  localparam int DIST_W      = 8;

  // Tick timer period: the count wraps from TICK_PERIOD-1 back to zero
  localparam logic [COUNT_W-1:0] TICK_PERIOD = 12'd2500;

  // floor(count*43/625) as (count*DIST_RECIP) >> DIST_SHIFT, exact for count < 2500
  localparam int                DIST_SHIFT = 21;
  localparam int                RECIP_W    = 18;
  localparam logic [RECIP_W-1:0] DIST_RECIP = 18'd144285;
  localparam int                PROD_W     = COUNT_W + RECIP_W;

  // Register map
  localparam int                ADDR_W            = 3;
  localparam logic              REG_TIMEOUT_TICKS = 1'b0;
  localparam logic [COUNT_W-1:0] TIMEOUT_RESET    = 12'd2000;

  // Request kinds carried in s_tuser
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

endpackage

`default_nettype wire

[sv/ultrasonic_echo_ranger.sv]
// Top level of the ultrasonic echo ranger: control state, distance scaling and output register.
//
// Usage:
//   Input words arrive on the s_ stream. s_tuser selects the kind: a tick word advances
//   the running measurement, a start word arms the channel in s_tdata (ignored unless idle).
//   s_tdata carries the channel and the current echo level of every sensor.
//   A measurement ends on the echo fall or on timeout and emits one word on the m_ stream:
//   channel and distance in centimetres in m_tdata, the timeout mark in m_tuser.
//   Throughput is one input word per clock while s_tready is high. The control state updates
//   in the accept cycle; the distance multiply sits in a second stage, so the result of the
//   tick word that ends a measurement passes the stage-one register, then the output register.
//   The two result stages form a pipeline with backpressure: while the receiver holds m_tready
//   low, the stages fill and s_tready drops only when both hold a result.
//   The timeout_ticks register sits at byte address 0 of the APB port; write it only
//   while the block is idle. Reset (rst, synchronous) returns to idle, clears the count,
//   the timeout mark and both result stages, and loads timeout_ticks with 2000.
`default_nettype none

module ultrasonic_echo_ranger (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // APB configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [uer_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  // Input stream
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [15:0]                s_tdata,   // [2:0] channel, [10:3] echo_levels, [15:11] zero
  input  wire logic                       s_tuser,   // [0] req_type
  // Result stream
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [15:0]                m_tdata,   // [2:0] done_channel, [10:3] distance_cm, [15:11] zero
  output logic                            m_tuser    // [0] timed_out
);

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_LOW  = 2'd1,
    PH_WAIT_HIGH = 2'd2,
    PH_WAIT_FALL = 2'd3
  } phase_t;

  localparam int CW = uer_pkg::CHAN_W;
  localparam int NW = uer_pkg::COUNT_W;

  // Configuration register
  logic [NW-1:0] timeout_ticks;
  logic          cfg_write;

  // Control state
  phase_t        phase, phase_next;
  logic [NW-1:0] tick_count, tick_count_next;
  logic          timeout_mark, timeout_mark_next;
  logic [CW-1:0] active_channel, active_channel_next;

  // Input word fields
  logic                      in_accept;
  logic [CW-1:0]             in_channel;
  logic [uer_pkg::ECHO_W-1:0] in_echo;
  logic                      level;
  logic [NW-1:0]             count_inc;

  // Result from the control step
  logic          res_fire;
  logic          res_zero;

  // Stage one: finished measurement waiting for scaling
  logic          st1_valid;
  logic [CW-1:0] st1_channel;
  logic [NW-1:0] st1_count;
  logic          st1_tmo;
  logic          st1_zero;
  logic          st1_ready;
  logic          st2_ready;

  logic [uer_pkg::PROD_W-1:0] product;
  logic [uer_pkg::DIST_W-1:0] distance;

  // APB: always ready, register selected by the word address bit
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == uer_pkg::REG_TIMEOUT_TICKS) ?
                     {{(32-NW){1'b0}}, timeout_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= uer_pkg::TIMEOUT_RESET;
    end else if (cfg_write && (paddr[2] == uer_pkg::REG_TIMEOUT_TICKS)) begin
      timeout_ticks <= pwdata[NW-1:0];
    end
  end

  // Handshake through the two result stages
  assign st2_ready = !m_tvalid || m_tready;
  assign st1_ready = !st1_valid || st2_ready;
  assign s_tready  = st1_ready;
  assign in_accept = s_tvalid && s_tready;

  assign in_channel = s_tdata[CW-1:0];
  assign in_echo    = s_tdata[CW +: uer_pkg::ECHO_W];
  assign level      = in_echo[active_channel];
  assign count_inc  = (tick_count + 1'b1 >= uer_pkg::TICK_PERIOD) ? '0 : tick_count + 1'b1;

  // Work out one control step for the incoming word
  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    timeout_mark_next   = timeout_mark;
    active_channel_next = active_channel;
    res_fire            = 1'b0;
    res_zero            = 1'b0;
    if (s_tuser == uer_pkg::REQ_START) begin
      if (phase == PH_IDLE && int'(in_channel) < uer_pkg::NUM_SENSORS) begin
        active_channel_next = in_channel;
        tick_count_next     = '0;
        timeout_mark_next   = 1'b0;
        phase_next          = PH_WAIT_LOW;
      end
    end else if (phase != PH_IDLE) begin
      tick_count_next = count_inc;
      if (count_inc == timeout_ticks) begin
        timeout_mark_next = 1'b1;
      end
      if (timeout_mark_next) begin
        // timeout wins over any edge; distance only counts once the echo rose
        res_fire   = 1'b1;
        res_zero   = (phase != PH_WAIT_FALL);
        phase_next = PH_IDLE;
      end else begin
        case (phase)
          PH_WAIT_LOW: begin
            if (!level) phase_next = PH_WAIT_HIGH;
          end
          PH_WAIT_HIGH: begin
            if (level) begin
              tick_count_next = '0;
              phase_next      = PH_WAIT_FALL;
            end
          end
          PH_WAIT_FALL: begin
            if (!level) begin
              res_fire   = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // Hold control state; advance it on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      timeout_mark   <= 1'b0;
      active_channel <= '0;
    end else if (in_accept) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      timeout_mark   <= timeout_mark_next;
      active_channel <= active_channel_next;
    end
  end

  // Stage one: capture a finished measurement
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (st1_ready) begin
      st1_valid <= in_accept && res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (st1_ready) begin
      st1_channel <= active_channel;
      st1_count   <= tick_count_next;
      st1_tmo     <= timeout_mark_next;
      st1_zero    <= res_zero;
    end
  end

  // Scale the count to centimetres by reciprocal multiply
  assign product  = uer_pkg::PROD_W'(st1_count) * uer_pkg::PROD_W'(uer_pkg::DIST_RECIP);
  assign distance = st1_zero ? '0 : product[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_W];

  // Stage two: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (st2_ready) begin
      m_tvalid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st2_ready && st1_valid) begin
      m_tdata <= {{(16-CW-uer_pkg::DIST_W){1'b0}}, distance, st1_channel};
      m_tuser <= st1_tmo;
    end
  end

  // Distance stays within the range of the tick period
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10:3] <= 8'd172))
    else $error("distance out of range");

  // An accepted start on an idle block arms it with a cleared count
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser == uer_pkg::REQ_START && phase == PH_IDLE)
    |=> (phase == PH_WAIT_LOW && tick_count == '0 && !timeout_mark))
    else $error("start did not arm the measurement");

  // A tick on an idle block leaves the count alone and yields no result
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser == uer_pkg::REQ_TICK && phase == PH_IDLE)
    |=> ($stable(tick_count) && phase == PH_IDLE && !st1_valid))
    else $error("idle tick changed state");

endmodule

`default_nettype wire
